// ===== hdl/dde_pkg.sv =====
// ----------------------------------------------------------------------------
// dde_pkg: shared types and constants for the diagonal energy block
// Field widths, request mode codes, register indexes and the
// controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package dde_pkg;

	localparam int VAL_W       = 48;  // table entries, energy offset
	localparam int OUT_W       = 56;  // saturated energy
	localparam int ACC_W       = 61;  // exact sum: 2081 terms of 48 bits
	localparam int ORB_W       = 6;   // orbital index
	localparam int CNT_W       = 7;   // orbital count, 0..64
	localparam int MODE_W      = 2;
	localparam int OCC_W       = 64;
	localparam int ADDR_FULL_W = 2 * ORB_W;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_W       = 48;

	localparam logic [CNT_W-1:0] ORBITAL_COUNT_RESET = 7'd64;

	localparam logic [MODE_W-1:0] MODE_ONE_BODY = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PAIR     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_QUERY    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_BASE_ENERGY   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORBITAL_COUNT = 1'd1;

	// controller -> datapath
	typedef struct packed {
		logic take;      // input request accepted this cycle
		logic step;      // issue one table read and advance i/j
		logic load_out;  // move saturated sum into output register
	} dde_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic last;        // scan sits on the final (i,j) of the query
		logic count_zero;  // effective orbital count is zero
		logic out_free;    // output register can take a result this cycle
	} dde_status_t;

endpackage

// ===== hdl/dde_ctrl.sv =====
// ----------------------------------------------------------------------------
// dde_ctrl: sequencer for the diagonal energy block
// Accepts requests when idle, walks a query through the table scan,
// drains the read pipeline and hands the result to the output register.
// ----------------------------------------------------------------------------
module dde_ctrl
	import dde_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [MODE_W-1:0] mode,
	input  dde_status_t       status,
	output dde_cmd_t          cmd,
	output logic              in_stall
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_RUN   = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d      = state_q;
		cmd.take     = 1'b0;
		cmd.step     = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.take = in_valid;
				if (in_valid && mode == MODE_QUERY) begin
					state_d = status.count_zero ? S_DRAIN : S_RUN;
				end
			end
			S_RUN: begin
				cmd.step = 1'b1;
				if (status.last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

// ===== hdl/dde_datapath.sv =====
// ----------------------------------------------------------------------------
// dde_datapath: table memory, scan counters, accumulator, output register
// One memory holds one-body terms on the diagonal (i,i) and pair terms
// at (lo,hi); a query reads row by row, one entry a cycle.
// ----------------------------------------------------------------------------
module dde_datapath
	import dde_pkg::*;
#(
	parameter int MAX_ORBITALS = 64
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  dde_cmd_t             cmd,
	input  logic [MODE_W-1:0]    mode,
	input  logic [ORB_W-1:0]     orbital_first,
	input  logic [ORB_W-1:0]     orbital_second,
	input  logic [VAL_W-1:0]     term_value,
	input  logic [OCC_W-1:0]     occupation,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 out_stall,
	output dde_status_t          status,
	output logic [OUT_W-1:0]     energy,
	output logic                 out_valid
);

	localparam int DEPTH = MAX_ORBITALS * MAX_ORBITALS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ORBITALS);

	// configuration registers
	logic [VAL_W-1:0] base_energy_q;
	logic [CNT_W-1:0] orbital_count_q;
	logic [CNT_W-1:0] cnt_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_energy_q   <= '0;
			orbital_count_q <= ORBITAL_COUNT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_BASE_ENERGY:   base_energy_q   <= cfg_data[VAL_W-1:0];
				CFG_ORBITAL_COUNT: orbital_count_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cnt_eff = (orbital_count_q > MAX_CNT) ? MAX_CNT : orbital_count_q;

	// write address decode
	logic [ORB_W-1:0]       lo;
	logic [ORB_W-1:0]       hi;
	logic [ADDR_FULL_W-1:0] wr_full;
	logic [AW-1:0]          wr_addr;
	logic                   mem_we;

	always_comb begin
		lo      = (orbital_first < orbital_second) ? orbital_first : orbital_second;
		hi      = (orbital_first < orbital_second) ? orbital_second : orbital_first;
		mem_we  = 1'b0;
		wr_full = '0;
		if (cmd.take && mode == MODE_ONE_BODY) begin
			mem_we  = ({1'b0, orbital_first} < MAX_CNT);
			wr_full = ADDR_FULL_W'(orbital_first) * ADDR_FULL_W'(MAX_ORBITALS)
				+ ADDR_FULL_W'(orbital_first);
		end else if (cmd.take && mode == MODE_PAIR) begin
			mem_we  = (lo != hi) && ({1'b0, hi} < MAX_CNT);
			wr_full = ADDR_FULL_W'(lo) * ADDR_FULL_W'(MAX_ORBITALS) + ADDR_FULL_W'(hi);
		end
	end

	assign wr_addr = wr_full[AW-1:0];

	// scan state
	logic [ORB_W-1:0] i_q;
	logic [ORB_W-1:0] j_q;
	logic [CNT_W-1:0] count_q;
	logic [OCC_W-1:0] occ_q;
	logic [ORB_W-1:0] last_idx;
	logic             row_end;
	logic             start;

	assign start    = cmd.take && (mode == MODE_QUERY);
	assign last_idx = ORB_W'(count_q - CNT_W'(1));
	assign row_end  = (j_q == last_idx);

	always_ff @(posedge clk) begin
		if (start) begin
			i_q     <= '0;
			j_q     <= '0;
			count_q <= cnt_eff;
			occ_q   <= occupation;
		end else if (cmd.step) begin
			if (row_end) begin
				i_q <= i_q + ORB_W'(1);
				j_q <= i_q + ORB_W'(1);
			end else begin
				j_q <= j_q + ORB_W'(1);
			end
		end
	end

	logic [ADDR_FULL_W-1:0] rd_full;
	logic [AW-1:0]          rd_addr;

	assign rd_full = ADDR_FULL_W'(i_q) * ADDR_FULL_W'(MAX_ORBITALS) + ADDR_FULL_W'(j_q);
	assign rd_addr = rd_full[AW-1:0];

	// table memory: one-body on the diagonal, pairs above it
	logic [VAL_W-1:0] table_mem [DEPTH];
	logic [VAL_W-1:0] rd_data_s1;
	logic             flag_s1;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[wr_addr] <= term_value;
		end
		if (cmd.step) begin
			rd_data_s1 <= table_mem[rd_addr];
			flag_s1    <= occ_q[i_q] & occ_q[j_q];
		end
	end

	logic val_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1 <= 1'b0;
		end else begin
			val_s1 <= cmd.step;
		end
	end

	// accumulator
	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] term_ext;

	assign term_ext = (val_s1 && flag_s1)
		? {{(ACC_W-VAL_W){rd_data_s1[VAL_W-1]}}, rd_data_s1} : '0;

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= {{(ACC_W-VAL_W){base_energy_q[VAL_W-1]}}, base_energy_q};
		end else begin
			acc_q <= acc_q + term_ext;
		end
	end

	// saturation and output register
	logic [OUT_W-1:0] sat;
	logic             fits;

	assign fits = (&acc_q[ACC_W-1:OUT_W-1]) || ~(|acc_q[ACC_W-1:OUT_W-1]);

	always_comb begin
		if (fits) begin
			sat = acc_q[OUT_W-1:0];
		end else if (acc_q[ACC_W-1]) begin
			sat = {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(OUT_W-1){1'b1}}};
		end
	end

	logic [OUT_W-1:0] energy_q;
	logic             out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			energy_q <= sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign energy            = energy_q;
	assign out_valid         = out_valid_q;
	assign status.out_free   = !out_valid_q || !out_stall;
	assign status.count_zero = (cnt_eff == '0);
	assign status.last       = row_end && (i_q == last_idx);

`ifndef SYNTH
	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("result load did not raise out_valid");

	a_step_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (count_q != '0) && ({1'b0, j_q} < count_q))
		else $error("scan step outside orbital count");

	a_step_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> j_q >= i_q)
		else $error("scan visited pair below the diagonal");

	a_no_early_load: assert property (@(posedge clk) disable iff (!arst_n)
		val_s1 |-> !cmd.load_out)
		else $error("result loaded while a table read is in flight");
`endif

endmodule

// ===== hdl/determinant_diagonal_energy.sv =====
// ----------------------------------------------------------------------------
// determinant_diagonal_energy: diagonal energy of an occupation bitstring
// Energy offset plus one-body and pair terms of occupied orbitals, saturated.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one request: mode 0 writes a
//   one-body entry, mode 1 writes a pair entry, mode 2 is a query, mode 3 is
//   dropped. Writes give no result.
//   A query with effective orbital count n scans n*(n+1)/2 table entries,
//   one per cycle out of the single table memory read port, then passes
//   through the drain and done states; the result is loaded into the
//   output register once that is free, and only then is the next request
//   taken. For n = 0 the scan is skipped.
//   Output channel (out_valid/out_stall) shows energy from an output
//   register; a new request is taken while that result is still stalled,
//   and a finished query waits for the register to free up.
//   Configuration (cfg_write/cfg_index/cfg_data) sets the energy offset and
//   orbital_count; write them only while no request is in flight.
//   Reset clears control state, the energy offset to 0 and orbital_count
//   to 64. Table contents are undefined until written.
// ----------------------------------------------------------------------------
module determinant_diagonal_energy
	import dde_pkg::*;
#(
	parameter int MAX_ORBITALS = 64
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [MODE_W-1:0]    mode,
	input  logic [ORB_W-1:0]     orbital_first,
	input  logic [ORB_W-1:0]     orbital_second,
	input  logic [VAL_W-1:0]     term_value,
	input  logic [OCC_W-1:0]     occupation,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [OUT_W-1:0]     energy,
	// configuration
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	dde_cmd_t    cmd;
	dde_status_t status;

	// sequencer: idle / scan / drain / hand-off
	dde_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.mode     (mode),
		.status   (status),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	// table memory, scan counters, accumulator and output register
	dde_datapath #(
		.MAX_ORBITALS (MAX_ORBITALS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.mode           (mode),
		.orbital_first  (orbital_first),
		.orbital_second (orbital_second),
		.term_value     (term_value),
		.occupation     (occupation),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_stall      (out_stall),
		.status         (status),
		.energy         (energy),
		.out_valid      (out_valid)
	);

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for determinant_diagonal_energy
// Loads part of both term tables, then sends directed and random requests
// through the valid/stall request channel under several config and idle
// phases. A local predictor keeps its own tables and register copies, and
// each energy result is checked in order against it.
// ----------------------------------------------------------------------------
module testbench;
	import dde_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam longint ENERGY_MAX = (64'sd1 <<< (OUT_W - 1)) - 1;
	localparam longint ENERGY_MIN = -ENERGY_MAX - 1;

	// orbitals 0..7 and 56..63 are the only ones with loaded table entries
	localparam logic [OCC_W-1:0] TABLE_BITS = 64'hFF00_0000_0000_00FF;

	localparam int HOLD_CYCLES    = 400;    // long receiver hold-off
	localparam int WATCHDOG_LIMIT = 10000;  // must outlast a full 64-orbital query
	localparam int SETTLE_CYCLES  = 8;      // idle gap before a register write
	localparam int REPORT_LIMIT   = 10;

	typedef struct {
		logic [MODE_W-1:0]        mode;
		logic [ORB_W-1:0]         orbital_first;
		logic [ORB_W-1:0]         orbital_second;
		logic signed [VAL_W-1:0]  term_value;
		logic [OCC_W-1:0]         occupation;
	} request_t;

	// DUT ports; every input has a known value from time zero
	logic                 clk            = 1'b0;
	logic                 arst_n         = 1'b0;
	logic                 in_valid       = 1'b0;
	logic                 in_stall;
	logic [MODE_W-1:0]    mode           = MODE_ONE_BODY;
	logic [ORB_W-1:0]     orbital_first  = '0;
	logic [ORB_W-1:0]     orbital_second = '0;
	logic [VAL_W-1:0]     term_value     = '0;
	logic [OCC_W-1:0]     occupation     = '0;
	logic                 out_valid;
	logic                 out_stall      = 1'b0;
	logic [OUT_W-1:0]     energy;
	logic                 cfg_write      = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index      = CFG_BASE_ENERGY;
	logic [CFG_W-1:0]     cfg_data       = '0;

	// predictor state: tables and register copies
	logic signed [VAL_W-1:0] one_body_val [64];
	logic signed [VAL_W-1:0] pair_val [64][64];
	logic signed [VAL_W-1:0] core_offset   = '0;
	logic [CNT_W-1:0]        orbital_limit = ORBITAL_COUNT_RESET;

	request_t         pending_requests [$];  // filled by the initial block
	logic [OUT_W-1:0] energy_due [$];        // expected energies, oldest first
	request_t         driven_req;

	int unsigned queued_count   = 0;
	int unsigned accepted_count = 0;
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles   = 0;
	int unsigned hold_left      = 0;
	int          send_idle_pct  = 0;
	int          stall_pct      = 0;
	logic        pressure_armed = 1'b0;
	logic        pressure_done  = 1'b0;

	determinant_diagonal_energy dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.orbital_first  (orbital_first),
		.orbital_second (orbital_second),
		.term_value     (term_value),
		.occupation     (occupation),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.energy         (energy),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Exact sum of core, occupied one-body terms and occupied pairs below the
	// effective orbital count, clamped to the 56-bit output range.
	function automatic logic [OUT_W-1:0] energy_of(logic [OCC_W-1:0] occ);
		longint sum;
		int     n;
		n   = (orbital_limit > CNT_W'(64)) ? 64 : int'(orbital_limit);
		sum = core_offset;
		for (int i = 0; i < n; i++) begin
			if (occ[i]) begin
				sum += one_body_val[i];
				for (int j = i + 1; j < n; j++) begin
					if (occ[j])
						sum += pair_val[i][j];
				end
			end
		end
		if (sum > ENERGY_MAX)
			sum = ENERGY_MAX;
		if (sum < ENERGY_MIN)
			sum = ENERGY_MIN;
		return sum[OUT_W-1:0];
	endfunction

	// Table writes update the local copy; a query queues its expected energy.
	function automatic void apply_request(request_t r);
		logic [ORB_W-1:0] lo;
		logic [ORB_W-1:0] hi;
		lo = (r.orbital_first < r.orbital_second) ? r.orbital_first : r.orbital_second;
		hi = (r.orbital_first < r.orbital_second) ? r.orbital_second : r.orbital_first;
		case (r.mode)
			MODE_ONE_BODY: one_body_val[r.orbital_first] = r.term_value;
			MODE_PAIR: begin
				// pair with both orbitals equal is dropped
				if (lo != hi)
					pair_val[lo][hi] = r.term_value;
			end
			MODE_QUERY: energy_due.insert(energy_due.size(), energy_of(r.occupation));
			default: ;  // unused mode: no effect, no result
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Request driver: a new request is only presented once the previous one
	// has gone (or none was up), so a stalled payload never moves.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				apply_request(driven_req);
				accepted_count++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					driven_req = pending_requests.pop_front();
					in_valid       <= 1'b1;
					mode           <= driven_req.mode;
					orbital_first  <= driven_req.orbital_first;
					orbital_second <= driven_req.orbital_second;
					term_value     <= driven_req.term_value;
					occupation     <= driven_req.occupation;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result receiver: random stalls, plus one long hold-off so the output
	// register backs up and the request side has to stall.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (pressure_armed && !pressure_done) begin
			out_stall     <= 1'b1;
			hold_left     <= HOLD_CYCLES;
			pressure_done <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Monitor: each taken result against the oldest expected energy.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (energy_due.size() == 0) begin
				if (mismatch_count < REPORT_LIMIT)
					$display("unexpected energy result %0d", $signed(energy));
				mismatch_count++;
			end else if (energy !== energy_due[0]) begin
				if (mismatch_count < REPORT_LIMIT)
					$display("energy mismatch: expected %0d got %0d",
						$signed(energy_due[0]), $signed(energy));
				mismatch_count++;
				void'(energy_due.pop_front());
			end else begin
				void'(energy_due.pop_front());
			end
		end
	end

	// Watchdog: too long without any request, result or register write.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// k in 0..15 maps onto the loaded orbitals 0..7 and 56..63
	function automatic logic [ORB_W-1:0] table_orbital(int k);
		return (k < 8) ? ORB_W'(k) : ORB_W'(k + 48);
	endfunction

	function automatic logic [ORB_W-1:0] pick_orbital();
		return table_orbital(int'($urandom_range(15)));
	endfunction

	// Occupation bits a query may carry: loaded orbitals, plus everything at
	// or above the current count since the block never reads those.
	function automatic logic [OCC_W-1:0] query_bits();
		int               n;
		logic [OCC_W-1:0] above;
		n     = (orbital_limit > CNT_W'(64)) ? 64 : int'(orbital_limit);
		above = (n >= 64) ? '0 : ~((64'd1 << n) - 64'd1);
		return TABLE_BITS | above;
	endfunction

	function automatic logic [VAL_W-1:0] random_term();
		case ($urandom_range(3))
			0: return VAL_MAX;
			1: return VAL_MIN;
			default: return VAL_W'({$urandom, $urandom});
		endcase
	endfunction

	task automatic queue_request(logic [MODE_W-1:0] m, logic [ORB_W-1:0] a,
			logic [ORB_W-1:0] b, logic [VAL_W-1:0] v, logic [OCC_W-1:0] occ);
		request_t r;
		r.mode           = m;
		r.orbital_first  = a;
		r.orbital_second = b;
		r.term_value     = v;
		r.occupation     = (m == MODE_QUERY) ? (occ & query_bits()) : occ;
		pending_requests.insert(pending_requests.size(), r);
		queued_count++;
	endtask

	// Mostly queries and table writes; payload fields the mode ignores still
	// carry random bits. Occupations range from sparse to dense.
	task automatic queue_random(int count);
		logic [MODE_W-1:0] m;
		logic [ORB_W-1:0]  a;
		logic [ORB_W-1:0]  b;
		logic [VAL_W-1:0]  v;
		logic [OCC_W-1:0]  occ;
		int                p;
		for (int k = 0; k < count; k++) begin
			p   = $urandom_range(99);
			a   = ORB_W'($urandom);
			b   = ORB_W'($urandom);
			v   = VAL_W'({$urandom, $urandom});
			occ = {$urandom, $urandom};
			case ($urandom_range(4))
				0: occ = occ & {$urandom, $urandom} & {$urandom, $urandom};
				1: occ = occ | {$urandom, $urandom};
				2: occ = '1;
				3: occ = 64'd1 << $urandom_range(63);
				default: ;
			endcase
			case ($urandom_range(6))
				0: v = VAL_MAX;
				1: v = VAL_MIN;
				default: ;
			endcase
			if (p < 40) begin
				m = MODE_QUERY;
			end else if (p < 60) begin
				m = MODE_ONE_BODY;
				a = pick_orbital();
			end else if (p < 95) begin
				m = MODE_PAIR;
				a = pick_orbital();
				b = pick_orbital();
				if ($urandom_range(6) == 0)
					b = a;
			end else begin
				m = MODE_UNUSED;
			end
			queue_request(m, a, b, v, occ);
		end
	endtask

	// Wait until every request is taken and every result has come back,
	// then give a trailing table write time to land.
	task automatic drain();
		while (accepted_count < queued_count || energy_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			CFG_BASE_ENERGY:   core_offset   = data[VAL_W-1:0];
			CFG_ORBITAL_COUNT: orbital_limit = data[CNT_W-1:0];
			default: ;
		endcase
	endtask

	// Register updates only with the block idle. Upper bits of the count
	// write carry noise; only the low field counts.
	task automatic configure(logic [VAL_W-1:0] core, int count, int send_pct, int stall_p);
		logic [CFG_W-1:0] d;
		drain();
		d = CFG_W'({$urandom, $urandom});
		d[CNT_W-1:0] = CNT_W'(count);
		write_register(CFG_BASE_ENERGY, core);
		write_register(CFG_ORBITAL_COUNT, d);
		send_idle_pct <= send_pct;
		stall_pct     <= stall_p;
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		logic [ORB_W-1:0] a;
		logic [ORB_W-1:0] b;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Table load with reset registers: orbitals 0..7 and 56..63 only.
		// Queries keep their occupation to those orbitals (plus bits at or
		// above the count), so no unloaded entry is ever summed.
		// Pair order is shuffled.
		for (int k = 0; k < 16; k++)
			queue_request(MODE_ONE_BODY, table_orbital(k), ORB_W'($urandom),
				random_term(), {$urandom, $urandom});
		for (int k = 0; k < 16; k++) begin
			for (int l = k + 1; l < 16; l++) begin
				a = table_orbital(k);
				b = table_orbital(l);
				if ($urandom_range(1))
					queue_request(MODE_PAIR, a, b, random_term(), {$urandom, $urandom});
				else
					queue_request(MODE_PAIR, b, a, random_term(), {$urandom, $urandom});
			end
		end

		// Directed requests at reset values: core 0, all 64 orbitals.
		queue_request(MODE_QUERY, '0, '0, '0, '1);
		queue_request(MODE_QUERY, ORB_W'(63), ORB_W'(63), VAL_MAX, 64'h0000_0000_0000_00FF);
		queue_request(MODE_QUERY, '0, ORB_W'(63), VAL_MIN, 64'hFF00_0000_0000_0000);
		queue_request(MODE_QUERY, '0, '0, '0, '0);
		queue_request(MODE_QUERY, '0, '0, '0, 64'h8000_0000_0000_0000);
		queue_request(MODE_ONE_BODY, ORB_W'(63), '0, VAL_MAX, '0);
		queue_request(MODE_PAIR, ORB_W'(63), ORB_W'(62), VAL_MIN, '1);  // reversed order
		queue_request(MODE_PAIR, ORB_W'(9), ORB_W'(9), VAL_MAX, '1);    // equal: dropped
		queue_request(MODE_UNUSED, ORB_W'(63), ORB_W'(63), VAL_MAX, '1); // no result
		queue_request(MODE_QUERY, '0, '0, '0, 64'hC000_0000_0000_0201);
		queue_request(MODE_QUERY, '0, '0, '0, 64'h8000_0000_0000_0001);

		// zero orbitals in use: query returns the core offset only
		configure(VAL_MAX, 0, 0, 0);
		queue_request(MODE_QUERY, '0, '0, '0, '1);
		queue_request(MODE_QUERY, '0, '0, '0, {$urandom, $urandom});

		// count above the table size acts as a full table
		configure(VAL_MIN, 127, 0, 0);
		queue_request(MODE_QUERY, '0, '0, '0, 64'hFFFF_FFFF_0000_0000);
		queue_request(MODE_QUERY, '0, '0, '0, '1);

		// single orbital in use
		configure(VAL_MIN, 1, 0, 0);
		queue_request(MODE_QUERY, '0, '0, '0, 64'h1);
		queue_request(MODE_QUERY, '0, '0, '0, 64'hFFFF_FFFF_FFFF_FFFE);

		// Random phases: count and idling vary; big counts are few.
		configure(VAL_W'({$urandom, $urandom}), 7, 0, 0);
		queue_random(16);
		pressure_armed <= 1'b1;  // receiver hold-off while requests keep coming

		configure(VAL_MAX, 1, 65, 0);
		queue_random(16);

		configure('0, 0, 0, 65);
		queue_random(16);

		configure(VAL_W'({$urandom, $urandom}), 12, 32, 32);
		queue_random(16);

		configure(VAL_MIN, 64, 0, 0);
		queue_random(16);

		configure(VAL_W'({$urandom, $urandom}), 127, 0, 65);
		queue_random(16);

		configure(VAL_W'({$urandom, $urandom}), $urandom_range(2, 20), 65, 0);
		queue_random(16);

		configure(VAL_W'({$urandom, $urandom}), $urandom_range(1, 64), 32, 32);
		queue_random(16);

		drain();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && energy_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/dde_pkg.sv
hdl/dde_ctrl.sv
hdl/dde_datapath.sv
hdl/determinant_diagonal_energy.sv
bench/testbench.sv
